### hw/rtl/jscm_pkg.sv
// ----------------------------------------------------------------------------
// jscm_pkg: shared types and constants of the joystick servo mapper
// Word layouts, register indexes, reset values and controller/datapath links.
// ----------------------------------------------------------------------------
package jscm_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF  = 8;

    // Widths fixed by the word layouts and the register map.
    localparam int FIELD_BITS  = 10;
    localparam int THRESH_BITS = 8;
    localparam int BASE_BITS   = 16;
    localparam int SPAN_BITS   = 12;
    localparam int PULSE_BITS  = 16;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 8'd20;
    localparam logic [BASE_BITS-1:0]   BASE_RESET   = 16'd3580;
    localparam logic [SPAN_BITS-1:0]   SPAN_RESET   = 12'd240;
    localparam logic [PULSE_BITS-1:0]  PULSE_RESET  = 16'd3700;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_HOLD_THRESHOLD = 2'd0;
    localparam cfg_index_t CFG_PULSE_BASE     = 2'd1;
    localparam cfg_index_t CFG_PULSE_SPAN     = 2'd2;

    typedef enum logic [1:0] {
        PH_CAPTURE_MAX = 2'd0,
        PH_CAPTURE_MIN = 2'd1,
        PH_OPERATE     = 2'd2
    } phase_t;

    typedef struct packed {
        logic                  button_down;
        logic [FIELD_BITS-1:0] x_sample;
        logic [FIELD_BITS-1:0] y_sample;
    } sample_t;

    typedef struct packed {
        logic [1:0]            phase_now;
        logic [PULSE_BITS-1:0] x_pulse;
        logic [PULSE_BITS-1:0] y_pulse;
        logic                  x_held;
        logic                  y_held;
        logic                  captured;
        logic                  span_error;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic mul;
        logic div_start;
        logic finish;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic operate;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

### hw/rtl/joystick_servo_calibrated_mapper.sv
// ----------------------------------------------------------------------------
// joystick_servo_calibrated_mapper: two-point calibrated joystick to servo map
// Result path: in the calibration phases the result register loads after the
// update and multiply steps; in the operate phase it loads after the bit-serial
// dividers, which run for both axes side by side, and the finish step.
// One word is in progress at a time; the next is taken the cycle after the
// result register loads. Reset restores the configuration registers and state
// at once.
// ----------------------------------------------------------------------------
module joystick_servo_calibrated_mapper #(
    parameter int SAMPLE_BITS = jscm_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = jscm_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  jscm_pkg::sample_t                  sample,
    output logic                               result_valid,
    input  logic                               result_stall,
    output jscm_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  jscm_pkg::cfg_index_t               cfg_index,
    input  logic [jscm_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    import jscm_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    jscm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    jscm_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (sample),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule

### hw/rtl/jscm_divider.sv
// ----------------------------------------------------------------------------
// jscm_divider: unsigned restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold until the
// next start.
// ----------------------------------------------------------------------------
module jscm_divider #(
    parameter int NW = 22,
    parameter int DW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient,
    output logic          rem_nonzero
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg, div_next;
    logic [DW:0]   shifted;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign ge      = shifted >= {1'b0, div_reg};
    assign done    = busy_reg && (cnt_reg == CW'(1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DW'(shifted - {1'b0, div_reg}) : DW'(shifted);
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient    = quo_reg;
    assign rem_nonzero = |rem_reg;

    a_busy_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with an empty step count");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !start) |=> !busy_reg)
        else $error("divider still busy after its last step");

endmodule

### hw/rtl/jscm_datapath.sv
// ----------------------------------------------------------------------------
// jscm_datapath: calibration state, locks and pulse arithmetic
// Holds the registers, the tick update, the multiply, two dividers, the
// pulse saturation and the result register.
// ----------------------------------------------------------------------------
module jscm_datapath #(
    parameter int SAMPLE_BITS = jscm_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = jscm_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  jscm_pkg::cmd_t                       cmd,
    output jscm_pkg::status_t                    status,
    input  jscm_pkg::sample_t                    sample,
    output jscm_pkg::result_t                    result,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    input  logic                                 cfg_valid,
    input  jscm_pkg::cfg_index_t                 cfg_index,
    input  logic [jscm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import jscm_pkg::*;

    localparam int S    = SAMPLE_BITS;
    localparam int NW   = SAMPLE_BITS + SPAN_BITS;
    localparam int PW   = SAMPLE_BITS + SPAN_BITS + 2;
    localparam int VW   = NW + 3;
    localparam int CMPW = (COUNT_BITS > THRESH_BITS) ? COUNT_BITS : THRESH_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration registers.
    logic [THRESH_BITS-1:0] thresh_reg;
    logic [BASE_BITS-1:0]   base_reg;
    logic [SPAN_BITS-1:0]   span_reg;

    // Tick state.
    phase_t                 phase_reg, phase_next;
    logic [COUNT_BITS-1:0]  hold_count_reg, hold_count_next;
    logic                   was_pressed_reg, was_pressed_next;
    logic [S-1:0]           x_high_reg, x_high_next, x_low_reg, x_low_next;
    logic [S-1:0]           y_high_reg, y_high_next, y_low_reg, y_low_next;
    logic                   x_lock_reg, x_lock_next, y_lock_reg, y_lock_next;
    logic                   cap_reg, cap_next;
    logic                   op_reg;
    logic                   err_reg;
    logic [PULSE_BITS-1:0]  x_out_reg, y_out_reg;

    // Latched samples and arithmetic pipeline.
    logic [S-1:0]           xs_reg, ys_reg;
    logic [NW-1:0]          x_pmag_reg, y_pmag_reg;
    logic [S-1:0]           x_dmag_reg, y_dmag_reg;
    logic                   x_neg_reg, y_neg_reg, x_dz_reg, y_dz_reg;

    logic                   result_valid_reg;
    result_t                result_reg;

    logic [31:0]            xs_wide, ys_wide;
    logic [S-1:0]           xs_in, ys_in;
    logic [COUNT_BITS-1:0]  count_inc;
    logic                   over;

    logic signed [S:0]      xn, xd, yn, yd;
    logic signed [PW-1:0]   span_s, xp, yp, xp_abs, yp_abs;
    logic signed [S:0]      xd_abs, yd_abs;

    logic                   x_done, y_done, x_rnz, y_rnz;
    logic [NW-1:0]          x_quo, y_quo;
    logic [PULSE_BITS-1:0]  x_map, y_map;

    // Floor-divided quotient with its sign applied, offset and saturated.
    function automatic logic [PULSE_BITS-1:0] pulse_of(
        input logic [NW-1:0]        quo,
        input logic                 rnz,
        input logic                 neg,
        input logic [BASE_BITS-1:0] base
    );
        logic [NW:0]          qmag;
        logic signed [VW-1:0] q;
        logic signed [VW-1:0] v;
        qmag = (neg && rnz) ? ((NW+1)'(quo) + (NW+1)'(1)) : (NW+1)'(quo);
        q    = neg ? -$signed(VW'(qmag)) : $signed(VW'(qmag));
        v    = $signed(VW'(base)) + q;
        if (v[VW-1])
            pulse_of = '0;
        else if (|v[VW-2:PULSE_BITS])
            pulse_of = {PULSE_BITS{1'b1}};
        else
            pulse_of = v[PULSE_BITS-1:0];
    endfunction

    assign xs_wide = 32'(sample.x_sample);
    assign ys_wide = 32'(sample.y_sample);
    assign xs_in   = xs_wide[S-1:0];
    assign ys_in   = ys_wide[S-1:0];

    assign count_inc = (hold_count_reg == COUNT_MAX) ? hold_count_reg
                                                     : hold_count_reg + COUNT_BITS'(1);
    assign over = CMPW'(hold_count_reg) > CMPW'(thresh_reg);

    // One poll tick of the phase, count and lock logic.
    always_comb
    begin
        phase_next       = phase_reg;
        hold_count_next  = hold_count_reg;
        was_pressed_next = was_pressed_reg;
        x_high_next      = x_high_reg;
        x_low_next       = x_low_reg;
        y_high_next      = y_high_reg;
        y_low_next       = y_low_reg;
        x_lock_next      = x_lock_reg;
        y_lock_next      = y_lock_reg;
        cap_next         = 1'b0;
        if (phase_reg != PH_OPERATE)
        begin
            if (sample.button_down)
            begin
                hold_count_next = count_inc;
                if (over)
                begin
                    if (phase_reg == PH_CAPTURE_MAX)
                    begin
                        x_high_next = xs_in;
                        y_high_next = ys_in;
                        phase_next  = PH_CAPTURE_MIN;
                    end
                    else
                    begin
                        x_low_next = xs_in;
                        y_low_next = ys_in;
                        phase_next = PH_OPERATE;
                    end
                    cap_next        = 1'b1;
                    hold_count_next = '0;
                end
            end
            else
            begin
                hold_count_next = '0;
            end
        end
        else
        begin
            if (sample.button_down)
            begin
                hold_count_next = count_inc;
                if (over && !was_pressed_reg)
                begin
                    if (!x_lock_reg)
                    begin
                        x_lock_next = 1'b1;
                        cap_next    = 1'b1;
                    end
                    else if (!y_lock_reg)
                    begin
                        y_lock_next = 1'b1;
                        cap_next    = 1'b1;
                    end
                    was_pressed_next = 1'b1;
                    hold_count_next  = '0;
                end
            end
            else
            begin
                hold_count_next  = '0;
                was_pressed_next = 1'b0;
            end
        end
    end

    // Signed differences and products against the calibration points.
    assign xn     = $signed({1'b0, xs_reg}) - $signed({1'b0, x_low_reg});
    assign xd     = $signed({1'b0, x_high_reg}) - $signed({1'b0, x_low_reg});
    assign yn     = $signed({1'b0, y_high_reg}) - $signed({1'b0, ys_reg});
    assign yd     = $signed({1'b0, y_high_reg}) - $signed({1'b0, y_low_reg});
    assign span_s = $signed(PW'({1'b0, span_reg}));
    assign xp     = PW'(xn) * span_s;
    assign yp     = PW'(yn) * span_s;
    assign xp_abs = xp[PW-1] ? -xp : xp;
    assign yp_abs = yp[PW-1] ? -yp : yp;
    assign xd_abs = xd[S] ? -xd : xd;
    assign yd_abs = yd[S] ? -yd : yd;

    jscm_divider #(.NW(NW), .DW(S)) u_x_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd.div_start),
        .dividend    (x_pmag_reg),
        .divisor     (x_dmag_reg),
        .done        (x_done),
        .quotient    (x_quo),
        .rem_nonzero (x_rnz)
    );

    jscm_divider #(.NW(NW), .DW(S)) u_y_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd.div_start),
        .dividend    (y_pmag_reg),
        .divisor     (y_dmag_reg),
        .done        (y_done),
        .quotient    (y_quo),
        .rem_nonzero (y_rnz)
    );

    assign x_map = pulse_of(x_quo, x_rnz, x_neg_reg, base_reg);
    assign y_map = pulse_of(y_quo, y_rnz, y_neg_reg, base_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg       <= THRESH_RESET;
            base_reg         <= BASE_RESET;
            span_reg         <= SPAN_RESET;
            phase_reg        <= PH_CAPTURE_MAX;
            hold_count_reg   <= '0;
            was_pressed_reg  <= 1'b0;
            x_high_reg       <= '0;
            x_low_reg        <= '0;
            y_high_reg       <= '0;
            y_low_reg        <= '0;
            x_lock_reg       <= 1'b0;
            y_lock_reg       <= 1'b0;
            cap_reg          <= 1'b0;
            op_reg           <= 1'b0;
            err_reg          <= 1'b0;
            x_out_reg        <= PULSE_RESET;
            y_out_reg        <= PULSE_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_HOLD_THRESHOLD: thresh_reg <= cfg_data[THRESH_BITS-1:0];
                    CFG_PULSE_BASE:     base_reg   <= cfg_data[BASE_BITS-1:0];
                    CFG_PULSE_SPAN:     span_reg   <= cfg_data[SPAN_BITS-1:0];
                    default:            ;
                endcase
            end
            if (cmd.accept)
            begin
                phase_reg       <= phase_next;
                hold_count_reg  <= hold_count_next;
                was_pressed_reg <= was_pressed_next;
                x_high_reg      <= x_high_next;
                x_low_reg       <= x_low_next;
                y_high_reg      <= y_high_next;
                y_low_reg       <= y_low_next;
                x_lock_reg      <= x_lock_next;
                y_lock_reg      <= y_lock_next;
                cap_reg         <= cap_next;
                op_reg          <= (phase_reg == PH_OPERATE);
                err_reg         <= 1'b0;
            end
            if (cmd.finish)
            begin
                if (!x_lock_reg && !x_dz_reg)
                    x_out_reg <= x_map;
                if (!y_lock_reg && !y_dz_reg)
                    y_out_reg <= y_map;
                err_reg <= (!x_lock_reg && x_dz_reg) || (!y_lock_reg && y_dz_reg);
            end
            if (cmd.load_out)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            xs_reg <= xs_in;
            ys_reg <= ys_in;
        end
        if (cmd.mul)
        begin
            x_pmag_reg <= xp_abs[NW-1:0];
            y_pmag_reg <= yp_abs[NW-1:0];
            x_dmag_reg <= xd_abs[S-1:0];
            y_dmag_reg <= yd_abs[S-1:0];
            x_neg_reg  <= xp[PW-1] ^ xd[S];
            y_neg_reg  <= yp[PW-1] ^ yd[S];
            x_dz_reg   <= (xd == '0);
            y_dz_reg   <= (yd == '0);
        end
        if (cmd.load_out)
        begin
            result_reg.phase_now  <= phase_reg;
            result_reg.x_pulse    <= x_out_reg;
            result_reg.y_pulse    <= y_out_reg;
            result_reg.x_held     <= x_lock_reg;
            result_reg.y_held     <= y_lock_reg;
            result_reg.captured   <= cap_reg;
            result_reg.span_error <= err_reg;
        end
    end

    assign status.operate  = op_reg;
    assign status.div_done = x_done;
    assign status.out_free = !result_valid_reg || !result_stall;
    assign result          = result_reg;
    assign result_valid    = result_valid_reg;

    a_y_after_x: assert property (@(posedge clk) disable iff (!rst_n)
        y_lock_reg |-> x_lock_reg)
        else $error("Y locked before X");

    a_lock_in_operate: assert property (@(posedge clk) disable iff (!rst_n)
        x_lock_reg |-> (phase_reg == PH_OPERATE))
        else $error("axis locked outside the operate phase");

    a_dividers_agree: assert property (@(posedge clk) disable iff (!rst_n)
        x_done == y_done)
        else $error("axis dividers out of step");

    a_err_operate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out && err_reg |-> op_reg)
        else $error("span error flagged during calibration");

endmodule

### hw/rtl/jscm_ctrl.sv
// ----------------------------------------------------------------------------
// jscm_ctrl: sequencer of the joystick servo mapper
// Steps each accepted word through update, multiply, divide (operate phase only) and output load.
// ----------------------------------------------------------------------------
module jscm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  jscm_pkg::status_t status,
    output jscm_pkg::cmd_t    cmd
);

    import jscm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_START,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = sample_valid;
                if (sample_valid)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = status.operate ? S_START : S_OUT;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.load_out = status.out_free;
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

    assign sample_stall = stall_reg;

    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> sample_stall)
        else $error("new word taken while one is in progress");

    a_fin_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> $past(state_reg == S_DIV))
        else $error("finish reached without a division");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result register overwritten while held");

endmodule

### tb/sv/tb_joystick_servo_calibrated_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_servo_calibrated_mapper: self-checking bench for the servo mapper
// Walks the block through max and min calibration, then operates it under
// several base/span/threshold settings and finally locks both axes. A
// scoreboard predicts each result word from every accepted sample word.
// ----------------------------------------------------------------------------
module tb_joystick_servo_calibrated_mapper;
    import jscm_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;

    // Predicts the mapper's result words and checks the words that come back.
    class servo_map_scoreboard;
        localparam logic [COUNT_BITS_DEF-1:0] COUNT_TOP = '1;

        logic [THRESH_BITS-1:0]    thresh;
        logic [BASE_BITS-1:0]      base;
        logic [SPAN_BITS-1:0]      span;
        phase_t                    phase;
        logic [COUNT_BITS_DEF-1:0] hold_count;
        bit                        was_pressed;
        logic [FIELD_BITS-1:0]     x_hi, x_lo, y_hi, y_lo;
        bit                        x_lock, y_lock;
        logic [PULSE_BITS-1:0]     x_pulse, y_pulse;
        result_t                   expected_words[$];
        int unsigned               errors, captures, span_errors;

        function new();
            thresh = THRESH_RESET;
            base = BASE_RESET;
            span = SPAN_RESET;
            phase = PH_CAPTURE_MAX;
            hold_count = '0;
            was_pressed = 0;
            x_hi = '0;
            x_lo = '0;
            y_hi = '0;
            y_lo = '0;
            x_lock = 0;
            y_lock = 0;
            x_pulse = PULSE_RESET;
            y_pulse = PULSE_RESET;
            errors = 0;
            captures = 0;
            span_errors = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_HOLD_THRESHOLD: thresh = data[THRESH_BITS-1:0];
                CFG_PULSE_BASE:     base = data[BASE_BITS-1:0];
                CFG_PULSE_SPAN:     span = data[SPAN_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Floor-divided linear map; returns 1 on a zero calibrated range.
        function bit scale_axis(longint num, longint den, inout logic [PULSE_BITS-1:0] pulse);
            longint prod, quot, v;
            if (den == 0)
                return 1;
            prod = num * longint'(span);
            quot = prod / den;
            if ((prod % den) != 0 && ((prod < 0) != (den < 0)))
                quot = quot - 1;
            v = longint'(base) + quot;
            if (v < 0)
                v = 0;
            else if (v > 65535)
                v = 65535;
            pulse = v[PULSE_BITS-1:0];
            return 0;
        endfunction

        function void predict_tick(sample_t s);
            result_t r;
            bit over, cap, err;
            cap = 0;
            err = 0;
            if (s.button_down) begin
                over = hold_count > thresh;
                if (hold_count != COUNT_TOP)
                    hold_count = hold_count + 1'b1;
            end else begin
                over = 0;
                hold_count = '0;
            end
            if (phase != PH_OPERATE) begin
                if (over) begin
                    if (phase == PH_CAPTURE_MAX) begin
                        x_hi = s.x_sample;
                        y_hi = s.y_sample;
                        phase = PH_CAPTURE_MIN;
                    end else begin
                        x_lo = s.x_sample;
                        y_lo = s.y_sample;
                        phase = PH_OPERATE;
                    end
                    cap = 1;
                    hold_count = '0;
                end
            end else begin
                if (!s.button_down) begin
                    was_pressed = 0;
                end else if (over && !was_pressed) begin
                    // A new qualified press locks X first, then Y.
                    if (!x_lock) begin
                        x_lock = 1;
                        cap = 1;
                    end else if (!y_lock) begin
                        y_lock = 1;
                        cap = 1;
                    end
                    was_pressed = 1;
                    hold_count = '0;
                end
                if (!x_lock && scale_axis(longint'(s.x_sample) - longint'(x_lo),
                                          longint'(x_hi) - longint'(x_lo), x_pulse))
                    err = 1;
                if (!y_lock && scale_axis(longint'(y_hi) - longint'(s.y_sample),
                                          longint'(y_hi) - longint'(y_lo), y_pulse))
                    err = 1;
            end
            r.phase_now = phase;
            r.x_pulse = x_pulse;
            r.y_pulse = y_pulse;
            r.x_held = x_lock;
            r.y_held = y_lock;
            r.captured = cap;
            r.span_error = err;
            expected_words.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_tick(result_t got);
            result_t want;
            if (expected_words.size() == 0) begin
                $error("result word arrived with no expectation pending");
                errors++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("phase_now", 16'(want.phase_now), 16'(got.phase_now));
            compare_field("x_pulse", want.x_pulse, got.x_pulse);
            compare_field("y_pulse", want.y_pulse, got.y_pulse);
            compare_field("x_held", 16'(want.x_held), 16'(got.x_held));
            compare_field("y_held", 16'(want.y_held), 16'(got.y_held));
            compare_field("captured", 16'(want.captured), 16'(got.captured));
            compare_field("span_error", 16'(want.span_error), 16'(got.span_error));
            if (want.captured)
                captures++;
            if (want.span_error)
                span_errors++;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     sample_valid = 1'b0;
    logic                     sample_stall;
    sample_t                  sample = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    result_t                  result;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    cfg_index_t               cfg_index = CFG_HOLD_THRESHOLD;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    servo_map_scoreboard sb;
    sample_t     stim_q[$];
    int unsigned words_pushed = 0;
    int unsigned words_accepted = 0;
    int unsigned reg_writes = 0;
    bit          no_gaps = 0;
    bit          hold_off_req = 0;

    joystick_servo_calibrated_mapper dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Sample side: a word stays offered until the block takes it.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (sample_valid && !sample_stall)
            begin
                sb.predict_tick(sample);
                words_accepted++;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (stim_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 11))
                begin
                    sample_valid <= 1'b1;
                    sample <= stim_q.pop_front();
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Result side, including one long hold-off that backs the block up.
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                sb.check_tick(result);
            if (hold_off_req)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_off_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= !no_gaps && ($urandom_range(0, 99) < 11);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles.", QUIET_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic push_word(bit btn, logic [FIELD_BITS-1:0] x, logic [FIELD_BITS-1:0] y);
        sample_t s;
        s.button_down = btn;
        s.x_sample = x;
        s.y_sample = y;
        stim_q.push_back(s);
        words_pushed++;
    endtask

    // Button held for a number of ticks with the stick parked, then released.
    task automatic hold_press(int ticks, logic [FIELD_BITS-1:0] x, logic [FIELD_BITS-1:0] y);
        repeat (ticks) push_word(1'b1, x, y);
        push_word(1'b0, x, y);
    endtask

    task automatic random_words(int count);
        repeat (count) push_word(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                                 10'($urandom_range(0, 1023)));
    endtask

    // Press/release sequences as a user makes them, with some noise mixed in.
    task automatic press_sequences(int count);
        int done;
        int len;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                random_words(3);
                done += 3;
            end
            else
            begin
                len = $urandom_range(1, 10);
                repeat (len) push_word(1'b1, 10'($urandom_range(0, 1023)),
                                       10'($urandom_range(0, 1023)));
                len = $urandom_range(1, 3);
                repeat (len) push_word(1'b0, 10'($urandom_range(0, 1023)),
                                       10'($urandom_range(0, 1023)));
                done += 13;
            end
        end
    endtask

    task automatic drain();
        while (words_accepted != words_pushed || sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
        reg_writes++;
    endtask

    // Unused upper bits of the narrow registers carry junk on purpose.
    task automatic set_mapping(logic [THRESH_BITS-1:0] thresh, logic [BASE_BITS-1:0] base,
                               logic [SPAN_BITS-1:0] span);
        drain();
        write_reg(CFG_HOLD_THRESHOLD, {8'($urandom), thresh});
        write_reg(CFG_PULSE_BASE, base);
        write_reg(CFG_PULSE_SPAN, {4'($urandom), span});
    endtask

    initial
    begin
        logic [FIELD_BITS-1:0] x_hi, x_lo, y_hi, y_lo;
        sb = new();
        x_hi = 10'($urandom_range(600, 1023));
        x_lo = ($urandom_range(0, 2) == 0) ? x_hi : 10'($urandom_range(0, 400));
        y_hi = 10'($urandom_range(0, 400));
        y_lo = 10'($urandom_range(600, 1023));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Calibration under reset settings: extremes, a short press, then max.
        push_word(1'b0, '0, '0);
        push_word(1'b0, '1, '1);
        push_word(1'b0, 10'h2AA, 10'h155);
        push_word(1'b0, 10'h155, 10'h2AA);
        hold_press(5, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        hold_press(23, x_hi, y_hi);
        drain();

        // A saturated count never beats the top threshold.
        write_reg(CFG_HOLD_THRESHOLD, 16'd255);
        hold_press(300, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        drain();
        write_reg(CFG_HOLD_THRESHOLD, 16'd254);
        hold_press(256, x_lo, y_lo);

        // Operating, no locks possible at the top threshold.
        set_mapping(8'd255, BASE_RESET, SPAN_RESET);
        push_word(1'b0, '0, '0);
        push_word(1'b0, '1, '1);
        push_word(1'b0, x_lo, y_lo);
        push_word(1'b0, x_hi, y_hi);
        hold_press(3, x_lo + 10'd1, y_lo - 10'd1);
        random_words(300);

        set_mapping(8'd255, 16'd0, 12'd4095);
        drain();
        no_gaps = 1;
        random_words(250);
        drain();
        no_gaps = 0;

        set_mapping(8'd255, 16'hFFFF, 12'd4095);
        random_words(200);
        set_mapping(8'd255, 16'd0, 12'd0);
        random_words(40);

        // Lock X with the lowest threshold, then map Y alone under back-pressure.
        set_mapping(8'd0, 16'($urandom), 12'($urandom));
        hold_press(2, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        set_mapping(8'd255, 16'($urandom_range(0, 8000)), 12'($urandom));
        hold_off_req = 1;
        random_words(300);

        // Ordinary presses lock Y, then further presses take nothing.
        set_mapping(8'($urandom_range(0, 6)), 16'($urandom), 12'($urandom));
        press_sequences(250);

        drain();
        repeat (40) @(posedge clk);

        $display("Ran %0d sample words through calibration and operation with %0d register writes.",
                 words_accepted, reg_writes);
        $display("Saw %0d captures or locks and %0d span errors; %0d words left unanswered.",
                 sb.captures, sb.span_errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### files.f
hw/rtl/jscm_pkg.sv
hw/rtl/jscm_divider.sv
hw/rtl/jscm_datapath.sv
hw/rtl/jscm_ctrl.sv
hw/rtl/joystick_servo_calibrated_mapper.sv
tb/sv/tb_joystick_servo_calibrated_mapper.sv
